// ----- sv/statement_lexer_defines.svh -----
// Assertion helpers shared by the lexer RTL.
`ifndef STATEMENT_LEXER_DEFINES_SVH
`define STATEMENT_LEXER_DEFINES_SVH

// Check a condition at every rising clock edge outside reset.
`define STL_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define STL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ----- sv/stl_pkg.sv -----
package stl_pkg;

    localparam int unsigned MAX_LEXEME_DEF = 255;
    localparam int unsigned QUEUE_DEPTH    = 4;
    localparam int unsigned QUEUE_AW       = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned TDATA_OUT_W    = 80;
    localparam logic [23:0] LINE_MAX       = 24'hFFFFFF;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_NUM   = 3'd1,
        MODE_ID    = 3'd2,
        MODE_COLON = 3'd3,
        MODE_HALT  = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        KIND_STMT_END = 3'd0,
        KIND_NUMBER   = 3'd1,
        KIND_IDENT    = 3'd2,
        KIND_OPERATOR = 3'd3,
        KIND_ASSIGN   = 3'd4,
        KIND_ERROR    = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_ILLEGAL  = 2'd1,
        ERR_COLON    = 2'd2,
        ERR_TOO_LONG = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start_pos;
        logic [7:0]  lexeme_length;
        logic [23:0] line_number;
        err_t        error_code;
        logic [7:0]  bad_char;
        logic        last;
    } res_t;

    typedef struct packed {
        logic [1:0] push_cnt;
        res_t       res0;
        res_t       res1;
    } core_out_t;

endpackage

// ----- sv/stl_core.sv -----
module stl_core #(
    parameter int unsigned MAX_LEXEME = stl_pkg::MAX_LEXEME_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [7:0]        ch,
    output stl_pkg::core_out_t core_out
);
    import stl_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_LEXEME);

    mode_t       mode_reg, mode_next;
    logic [31:0] lex_start_reg, lex_start_next;
    logic [7:0]  lex_len_reg, lex_len_next;
    logic [7:0]  lex_first_reg, lex_first_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [23:0] line_reg, line_next;
    logic [23:0] lex_line_reg, lex_line_next;

    logic  is_digit, is_letter, is_op, is_sep;
    logic  idle_emit, idle_begin;
    kind_t idle_kind;
    err_t  idle_err;
    mode_t idle_mode;
    logic  more, too_long;
    res_t  idle_res, term_res;

    // Character classes
    always_comb begin
        is_digit  = (ch >= 8'h30) && (ch <= 8'h39);
        is_letter = ((ch >= 8'h61) && (ch <= 8'h7A)) || ((ch >= 8'h41) && (ch <= 8'h5A));
        is_op     = (ch == CH_PLUS) || (ch == CH_MINUS) || (ch == CH_STAR) || (ch == CH_SLASH);
        is_sep    = (ch == CH_NUL) || (ch == CH_SPACE) || (ch == CH_TAB) ||
                    (ch == CH_CR) || (ch == CH_LF);
    end

    // Decode of a byte seen in idle mode
    always_comb begin
        idle_emit  = 1'b0;
        idle_begin = 1'b0;
        idle_kind  = KIND_STMT_END;
        idle_err   = ERR_NONE;
        idle_mode  = MODE_IDLE;
        if (ch == CH_SEMI) begin
            idle_emit = 1'b1;
        end else if (is_op) begin
            idle_emit = 1'b1;
            idle_kind = KIND_OPERATOR;
        end else if (ch == CH_COLON) begin
            idle_begin = 1'b1;
            idle_mode  = MODE_COLON;
        end else if (is_digit) begin
            idle_begin = 1'b1;
            idle_mode  = MODE_NUM;
        end else if (is_letter) begin
            idle_begin = 1'b1;
            idle_mode  = MODE_ID;
        end else if (!is_sep) begin
            idle_emit = 1'b1;
            idle_kind = KIND_ERROR;
            idle_err  = ERR_ILLEGAL;
            idle_mode = MODE_HALT;
        end
        idle_res = '{kind: idle_kind, start_pos: byte_pos_reg, lexeme_length: 8'd1,
                     line_number: line_reg, error_code: idle_err, bad_char: ch,
                     last: 1'b0};
    end

    always_comb begin
        more     = is_digit || ((mode_reg == MODE_ID) && is_letter);
        too_long = lex_len_reg >= MAX_LEN;
        term_res = '{kind: (mode_reg == MODE_NUM) ? KIND_NUMBER : KIND_IDENT,
                     start_pos: lex_start_reg, lexeme_length: lex_len_reg,
                     line_number: lex_line_reg, error_code: ERR_NONE,
                     bad_char: lex_first_reg, last: 1'b0};
    end

    // Next state
    always_comb begin
        mode_next      = mode_reg;
        lex_start_next = lex_start_reg;
        lex_len_next   = lex_len_reg;
        lex_first_next = lex_first_reg;
        byte_pos_next  = byte_pos_reg;
        line_next      = line_reg;
        lex_line_next  = lex_line_reg;
        if (in_fire && (mode_reg != MODE_HALT)) begin
            byte_pos_next = byte_pos_reg + 32'd1;
            if ((ch == CH_LF) && (line_reg != LINE_MAX)) begin
                line_next = line_reg + 24'd1;
            end
            unique case (mode_reg)
                MODE_NUM, MODE_ID: begin
                    if (more) begin
                        if (too_long) begin
                            mode_next = MODE_HALT;
                        end else begin
                            lex_len_next = lex_len_reg + 8'd1;
                        end
                    end else begin
                        mode_next = idle_mode;
                    end
                end
                MODE_COLON: begin
                    mode_next = (ch == CH_EQ) ? MODE_IDLE : MODE_HALT;
                end
                default: begin
                    mode_next = idle_mode;
                end
            endcase
            // A byte seen in idle mode, or one that terminates a lexeme, may open a new lexeme
            if ((mode_reg != MODE_COLON) && !((mode_reg != MODE_IDLE) && more) && idle_begin) begin
                lex_start_next = byte_pos_reg;
                lex_len_next   = 8'd1;
                lex_first_next = ch;
                lex_line_next  = line_reg;
            end
        end
    end

    // Results
    always_comb begin
        core_out = '0;
        if (in_fire && (mode_reg != MODE_HALT)) begin
            unique case (mode_reg)
                MODE_NUM, MODE_ID: begin
                    if (more) begin
                        if (too_long) begin
                            core_out.push_cnt = 2'd1;
                            core_out.res0 = '{kind: KIND_ERROR, start_pos: lex_start_reg,
                                              lexeme_length: lex_len_reg,
                                              line_number: lex_line_reg,
                                              error_code: ERR_TOO_LONG, bad_char: ch,
                                              last: 1'b1};
                        end
                    end else begin
                        core_out.res0 = term_res;
                        if (idle_emit) begin
                            core_out.push_cnt = 2'd2;
                            core_out.res1 = idle_res;
                            core_out.res1.last = 1'b1;
                        end else begin
                            core_out.push_cnt = 2'd1;
                            core_out.res0.last = 1'b1;
                        end
                    end
                end
                MODE_COLON: begin
                    core_out.push_cnt = 2'd1;
                    if (ch == CH_EQ) begin
                        core_out.res0 = '{kind: KIND_ASSIGN, start_pos: lex_start_reg,
                                          lexeme_length: 8'd2, line_number: lex_line_reg,
                                          error_code: ERR_NONE, bad_char: lex_first_reg,
                                          last: 1'b1};
                    end else begin
                        core_out.res0 = '{kind: KIND_ERROR, start_pos: lex_start_reg,
                                          lexeme_length: 8'd1, line_number: lex_line_reg,
                                          error_code: ERR_COLON, bad_char: ch,
                                          last: 1'b1};
                    end
                end
                default: begin
                    if (idle_emit) begin
                        core_out.push_cnt = 2'd1;
                        core_out.res0 = idle_res;
                        core_out.res0.last = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            lex_start_reg <= '0;
            lex_len_reg   <= '0;
            lex_first_reg <= '0;
            byte_pos_reg  <= '0;
            line_reg      <= 24'd1;
            lex_line_reg  <= 24'd1;
        end else begin
            mode_reg      <= mode_next;
            lex_start_reg <= lex_start_next;
            lex_len_reg   <= lex_len_next;
            lex_first_reg <= lex_first_next;
            byte_pos_reg  <= byte_pos_next;
            line_reg      <= line_next;
            lex_line_reg  <= lex_line_next;
        end
    end

endmodule

// ----- sv/stl_queue.sv -----
module stl_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  stl_pkg::core_out_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_ready,
    output stl_pkg::res_t      out_res
);
    import stl_pkg::*;

    res_t                mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;
    logic                pop;

    always_comb begin
        room        = count_reg <= QUEUE_CW'(QUEUE_DEPTH - 2);
        out_valid   = count_reg != '0;
        out_res     = mem[rd_ptr_reg];
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push.push_cnt);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + QUEUE_CW'(push.push_cnt) - QUEUE_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.push_cnt != 2'd0) begin
            mem[wr_ptr_reg] <= push.res0;
        end
        if (push.push_cnt == 2'd2) begin
            mem[wr_ptr_reg + QUEUE_AW'(1)] <= push.res1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- sv/statement_lexer.sv -----
// Results are registered in a four-entry result queue and offered on m_tvalid in order.
// Throughput: one byte per cycle while s_tready is high; a byte can yield two results, drained
// at one per cycle while m_tready is high, and s_tready drops when fewer than two slots are free.
// Reset (aresetn low, synchronous): idle mode, position zero, line one, queue empty.
// After any error result the block takes and discards bytes until reset.
`include "statement_lexer_defines.svh"

module statement_lexer #(
    parameter int unsigned MAX_LEXEME = stl_pkg::MAX_LEXEME_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // [7:0] ch
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [2:0] token_kind, [34:3] start_pos, [42:35] lexeme_length,
    // [66:43] line_number, [68:67] error_code, [76:69] bad_char, rest zero
    output logic [stl_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import stl_pkg::*;

    core_out_t core_out;
    res_t      out_res;
    logic      room;
    logic      in_fire;

    assign s_tready = room;
    assign in_fire  = s_tvalid && room;

    stl_core #(
        .MAX_LEXEME(MAX_LEXEME)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (in_fire),
        .ch      (s_tdata),
        .core_out(core_out)
    );

    stl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (core_out),
        .room     (room),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (out_res)
    );

    assign m_tdata = {3'b000, out_res.bad_char, out_res.error_code, out_res.line_number,
                      out_res.lexeme_length, out_res.start_pos, out_res.kind};
    assign m_tlast = out_res.last;

    `STL_ASSERT_IMPLY(a_two_results_order, core_out.push_cnt == 2'd2,
        core_out.res1.last && !core_out.res0.last && core_out.res0.kind != KIND_ERROR,
        "second result must be the last and follow a token")
    `STL_ASSERT_IMPLY(a_error_is_last, m_tvalid && out_res.kind == KIND_ERROR,
        m_tlast && out_res.error_code != ERR_NONE, "error result must close the request")
    `STL_ASSERT_IMPLY(a_token_no_error, m_tvalid && out_res.kind != KIND_ERROR,
        out_res.error_code == ERR_NONE, "token result carries an error code")
    `STL_ASSERT_ALWAYS(a_no_push_without_accept, in_fire || core_out.push_cnt == 2'd0,
        "result produced without an accepted byte")

endmodule

// ----- test/statement_lexer_test.sv -----
module statement_lexer_test;
    import stl_pkg::*;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        res_t       res;
    } source_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [7:0] ch
    logic                   m_tvalid;
    logic                   m_tready;
    // [2:0] token_kind, [34:3] start_pos, [42:35] lexeme_length,
    // [66:43] line_number, [68:67] error_code, [76:69] bad_char, rest zero
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;

    logic                   sink_ready;
    logic                   hold_off = 1'b0;

    assign m_tready = sink_ready && !hold_off;

    statement_lexer DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Lexer state as the tokenizer should hold it
    mode_t       cur_mode;
    logic [31:0] tok_start;
    logic [7:0]  tok_len;
    logic [7:0]  tok_first;
    logic [31:0] next_pos;
    logic [23:0] cur_line;
    logic [23:0] tok_line;

    res_t        step_tokens[$];
    res_t        awaited_tokens[$];
    source_row_t stimulus[$];
    source_row_t directed_rows[27];

    logic [7:0]  blank_chars[4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    logic [7:0]  op_chars[4]    = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    logic [7:0]  odd_chars[6]   = '{CH_EQ, 8'h01, 8'h21, 8'h40, 8'h5F, 8'h7F};

    int          fail_count;
    int          results_seen;
    int          kind_seen[6];

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic [7:0] rand_letter();
        int unsigned k;
        k = $urandom_range(0, 51);
        return (k < 26) ? 8'(8'h61 + k) : 8'(8'h41 + k - 26);
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'(8'h30 + $urandom_range(0, 9));
    endfunction

    function automatic res_t token(kind_t k, logic [31:0] at, logic [7:0] len,
                                   logic [23:0] ln, logic [7:0] bc);
        res_t r;
        r = '{kind: k, start_pos: at, lexeme_length: len, line_number: ln,
              error_code: ERR_NONE, bad_char: bc, last: 1'b1};
        return r;
    endfunction

    function automatic void emit(kind_t k, logic [31:0] at, logic [7:0] len,
                                 logic [23:0] ln, err_t e, logic [7:0] bc);
        res_t r;
        r = '{kind: k, start_pos: at, lexeme_length: len, line_number: ln,
              error_code: e, bad_char: bc, last: 1'b0};
        step_tokens.push_back(r);
    endfunction

    function automatic void open_lexeme(mode_t m, logic [7:0] c, logic [31:0] at);
        cur_mode  = m;
        tok_start = at;
        tok_len   = 8'd1;
        tok_first = c;
        tok_line  = cur_line;
    endfunction

    function automatic void lex_fresh(logic [7:0] c, logic [31:0] at);
        if (c == CH_SEMI) begin
            emit(KIND_STMT_END, at, 8'd1, cur_line, ERR_NONE, c);
        end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH}) begin
            emit(KIND_OPERATOR, at, 8'd1, cur_line, ERR_NONE, c);
        end else if (c == CH_COLON) begin
            open_lexeme(MODE_COLON, c, at);
        end else if (is_digit(c)) begin
            open_lexeme(MODE_NUM, c, at);
        end else if (is_letter(c)) begin
            open_lexeme(MODE_ID, c, at);
        end else if (!(c inside {CH_NUL, CH_SPACE, CH_TAB, CH_CR, CH_LF})) begin
            emit(KIND_ERROR, at, 8'd1, cur_line, ERR_ILLEGAL, c);
            cur_mode = MODE_HALT;
        end
    endfunction

    // Advance the tokenizer by one byte; the tokens it closes land in step_tokens.
    function automatic void lex_byte(logic [7:0] c);
        logic [31:0] at;
        res_t        tail;
        step_tokens.delete();
        if (cur_mode == MODE_HALT)
            return;
        at       = next_pos;
        next_pos = next_pos + 32'd1;
        if (cur_mode == MODE_NUM || cur_mode == MODE_ID) begin
            if (is_digit(c) || (cur_mode == MODE_ID && is_letter(c))) begin
                if (tok_len >= MAX_LEXEME_DEF) begin
                    emit(KIND_ERROR, tok_start, tok_len, tok_line, ERR_TOO_LONG, c);
                    cur_mode = MODE_HALT;
                end else begin
                    tok_len = tok_len + 8'd1;
                end
            end else begin
                emit(cur_mode == MODE_NUM ? KIND_NUMBER : KIND_IDENT, tok_start, tok_len,
                     tok_line, ERR_NONE, tok_first);
                cur_mode = MODE_IDLE;
                lex_fresh(c, at);
            end
        end else if (cur_mode == MODE_COLON) begin
            if (c == CH_EQ) begin
                emit(KIND_ASSIGN, tok_start, 8'd2, tok_line, ERR_NONE, tok_first);
                cur_mode = MODE_IDLE;
            end else begin
                emit(KIND_ERROR, tok_start, 8'd1, tok_line, ERR_COLON, c);
                cur_mode = MODE_HALT;
            end
        end else begin
            lex_fresh(c, at);
        end
        if (c == CH_LF && cur_line != LINE_MAX)
            cur_line = cur_line + 24'd1;
        if (step_tokens.size() > 0) begin
            tail      = step_tokens.pop_back();
            tail.last = 1'b1;
            step_tokens.push_back(tail);
        end
    endfunction

    function automatic void add_byte(logic [7:0] c);
        source_row_t row;
        row.ch    = c;
        row.typed = 1'b0;
        row.res   = '0;
        stimulus.push_back(row);
    endfunction

    // Queue a number or identifier run of len bytes.
    function automatic void add_run(bit ident, int len);
        add_byte(ident ? rand_letter() : rand_digit());
        for (int k = 1; k < len; k++)
            add_byte((ident && $urandom_range(0, 1)) ? rand_letter() : rand_digit());
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            fail_count++;
        end
    endfunction

    // Hold the result side off for a long stretch once traffic is flowing.
    initial begin : long_hold
        wait (results_seen >= 150);
        @(negedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(negedge aclk);
        hold_off <= 1'b0;
    end

    // Result side: random stalls and calm stretches.
    initial begin : result_sink
        int unsigned pause;
        res_t        want;
        sink_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            pause = (((results_seen / 40) % 3) == 1) ? 0 : $urandom_range(0, 19);
            if (pause > 0) begin
                sink_ready <= 1'b0;
                repeat (pause) @(negedge aclk);
            end
            sink_ready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
            results_seen++;
            if (awaited_tokens.size() == 0) begin
                $display("%0t: unexpected result, actual %0h last %0b",
                         $time, m_tdata, m_tlast);
                fail_count++;
            end else begin
                want = awaited_tokens.pop_front();
                kind_seen[int'(want.kind)]++;
                check_field("token_kind", 32'(want.kind), 32'(m_tdata[2:0]));
                check_field("start_pos", want.start_pos, m_tdata[34:3]);
                check_field("lexeme_length", 32'(want.lexeme_length), 32'(m_tdata[42:35]));
                check_field("line_number", 32'(want.line_number), 32'(m_tdata[66:43]));
                check_field("error_code", 32'(want.error_code), 32'(m_tdata[68:67]));
                check_field("bad_char", 32'(want.bad_char), 32'(m_tdata[76:69]));
                check_field("padding", '0, 32'(m_tdata[TDATA_OUT_W-1:77]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
            @(negedge aclk);
        end
    end

    initial begin : run_limit
        #5_000_000;
        $display("[statement_lexer] ERROR");
        $finish;
    end

    initial begin : byte_source
        int          len;
        int          run;
        int          pick;
        int unsigned gap;
        err_t        closing_err;
        logic [7:0]  c;

        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        cur_mode  = MODE_IDLE;
        tok_start = '0;
        tok_len   = '0;
        tok_first = '0;
        next_pos  = '0;
        cur_line  = 24'd1;
        tok_line  = 24'd1;

        directed_rows = '{
            '{CH_SEMI,  1'b1, token(KIND_STMT_END, 0, 1, 1, CH_SEMI)},
            '{CH_PLUS,  1'b1, token(KIND_OPERATOR, 1, 1, 1, CH_PLUS)},
            '{CH_MINUS, 1'b0, '0},
            '{CH_STAR,  1'b0, '0},
            '{CH_SLASH, 1'b0, '0},
            '{8'h30,    1'b0, '0},
            '{8'h39,    1'b0, '0},
            '{CH_SPACE, 1'b1, token(KIND_NUMBER, 5, 2, 1, 8'h30)},
            '{8'h41,    1'b0, '0},
            '{8'h7A,    1'b0, '0},
            '{8'h5A,    1'b0, '0},
            '{8'h39,    1'b0, '0},
            '{CH_TAB,   1'b0, '0},
            '{CH_COLON, 1'b0, '0},
            '{CH_EQ,    1'b1, token(KIND_ASSIGN, 13, 2, 1, CH_COLON)},
            '{8'h61,    1'b0, '0},
            '{CH_SEMI,  1'b0, '0},
            '{CH_LF,    1'b0, '0},
            '{CH_CR,    1'b0, '0},
            '{8'h37,    1'b0, '0},
            '{CH_NUL,   1'b1, token(KIND_NUMBER, 19, 1, 2, 8'h37)},
            '{8'h62,    1'b0, '0},
            '{CH_COLON, 1'b0, '0},
            '{CH_EQ,    1'b0, '0},
            '{8'h35,    1'b0, '0},
            '{CH_PLUS,  1'b0, '0},
            '{CH_NUL,   1'b0, '0}
        };
        foreach (directed_rows[i])
            stimulus.push_back(directed_rows[i]);

        // Longest legal lexemes first, then mostly short well-formed fragments.
        add_run(1'b1, MAX_LEXEME_DEF);
        add_byte(CH_SPACE);
        add_run(1'b0, MAX_LEXEME_DEF);
        add_byte(CH_LF);
        run = 0;
        while (stimulus.size() < 1427) begin
            pick = $urandom_range(0, 11);
            if (pick < 5) begin
                len = ($urandom_range(0, 99) == 0) ? $urandom_range(100, 255)
                                                   : $urandom_range(1, 12);
                // split adjacent runs before they could pass the lexeme limit
                if (run + len > MAX_LEXEME_DEF) begin
                    add_byte(CH_SPACE);
                    run = 0;
                end
                add_run(pick < 3, len);
                run += len;
            end else begin
                case (pick)
                    5: add_byte(op_chars[$urandom_range(0, 3)]);
                    6: add_byte(CH_SEMI);
                    7: begin
                        add_byte(CH_COLON);
                        add_byte(CH_EQ);
                    end
                    8: add_byte(CH_NUL);
                    default: add_byte(blank_chars[$urandom_range(0, 3)]);
                endcase
                run = 0;
            end
        end

        // One error halts the lexer for good, so close the run with one of them.
        closing_err = err_t'($urandom_range(1, 3));
        case (closing_err)
            ERR_ILLEGAL: add_byte($urandom_range(0, 1) ? 8'($urandom_range(128, 255))
                                                        : odd_chars[$urandom_range(0, 5)]);
            ERR_COLON: begin
                add_byte(CH_COLON);
                do c = 8'($urandom_range(0, 255)); while (c == CH_EQ);
                add_byte(c);
            end
            default: begin
                add_byte(CH_SPACE);
                add_run(1'($urandom_range(0, 1)), MAX_LEXEME_DEF + 1);
            end
        endcase
        add_byte(8'hFF);
        add_byte(8'h80);
        repeat (20) add_byte(8'($urandom_range(0, 255)));

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Hold each request until the lexer takes it.
        foreach (stimulus[i]) begin
            gap = (((i / 64) % 3) == 0) ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= stimulus[i].ch;
            do @(posedge aclk); while (!s_tready);
            lex_byte(stimulus[i].ch);
            if (stimulus[i].typed)
                awaited_tokens.push_back(stimulus[i].res);
            else
                foreach (step_tokens[k])
                    awaited_tokens.push_back(step_tokens[k]);
            @(negedge aclk);
        end
        s_tvalid <= 1'b0;

        while (awaited_tokens.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Lexed %0d bytes into %0d results: %0d numbers, %0d identifiers, %0d operators,",
                 stimulus.size(), results_seen, kind_seen[KIND_NUMBER], kind_seen[KIND_IDENT],
                 kind_seen[KIND_OPERATOR]);
        $display("%0d assignments, %0d statement ends, %0d error results (closing case %s).",
                 kind_seen[KIND_ASSIGN], kind_seen[KIND_STMT_END], kind_seen[KIND_ERROR],
                 closing_err.name());
        if (fail_count == 0)
            $display("[statement_lexer] OK");
        else
            $display("[statement_lexer] ERROR");
        $finish;
    end

endmodule
